// ===== rtl/core/ssoc_pkg.sv =====
// shared types and codes for the sorted store occurrence counter
// no dependencies; imported by ssoc_ram and sorted_store_occurrence_count
`timescale 1ns / 1ps

package ssoc_pkg;

    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } ssoc_cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_ORDER = 2'd2
    } ssoc_status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_PROBE,
        ST_RESP
    } ssoc_state_t;

endpackage

// ===== rtl/core/ssoc_ram.sv =====
// simple dual-port value store: one write port, one read port, registered read data
// depends on ssoc_pkg
`timescale 1ns / 1ps

module ssoc_ram
    import ssoc_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 20
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sorted_store_occurrence_count.sv =====
// top level of the sorted store occurrence counter: stream handshake, append logic,
// binary-search sequencer; depends on ssoc_pkg and ssoc_ram
`timescale 1ns / 1ps

// usage
//   slave channel s_*: one transaction per command; s_tuser carries the command
//   (append, query, clear), s_tdata the value
//   master channel m_*: one transaction per command with match count and status
//   append stores the value at the end of the store if there is room and the value
//   is not below the last one; otherwise status flags full or out of order
//   query counts entries equal to the value as upper bound minus lower bound,
//   both found by binary search over the filled part of the store
//   append, clear and unknown commands go from accept straight to the response state;
//   a query runs a lower-bound and then an upper-bound binary search, one probe per cycle
//   through the single read port of the store memory
//   (the upper-bound search starts at the lower bound, so it is often shorter)
//   one command is in work at a time; s_tready is high while the sequencer idles
//   the result sits in an output register, so a new command is taken while the
//   receiver stalls; the sequencer only waits if a second result is ready
//   reset empties the store (fill level and last value to zero); memory contents
//   are not cleared, entries above the fill level are never read
module sorted_store_occurrence_count
    import ssoc_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 20
) (
    input  logic clk,
    input  logic rst_n,
    // command transactions
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [8*((VALUE_BITS+7)/8)-1:0]        s_tdata,  // value
    input  logic [CMD_BITS-1:0]                    s_tuser,  // command
    // result transactions
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [8*(($clog2(DEPTH+1)+9)/8)-1:0]   m_tdata   // match_count, status
);

    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OUT_BITS  = CNT_BITS + STATUS_BITS;
    localparam int M_WIDTH   = 8 * ((OUT_BITS + 7) / 8);

    // sequencer and store state
    ssoc_state_t           state_reg, state_next;
    logic [CNT_BITS-1:0]   fill_reg, fill_next;
    logic [VALUE_BITS-1:0] last_reg, last_next;
    logic                  strict_reg, strict_next;
    logic                  out_valid_reg, out_valid_next;

    // search and result payload
    logic [VALUE_BITS-1:0] target_reg, target_next;
    logic [CNT_BITS-1:0]   lo_reg, lo_next;
    logic [CNT_BITS-1:0]   hi_reg, hi_next;
    logic [CNT_BITS-1:0]   mid_reg, mid_next;
    logic [CNT_BITS-1:0]   lower_reg, lower_next;
    logic [CNT_BITS-1:0]   res_count_reg, res_count_next;
    ssoc_status_t          res_status_reg, res_status_next;
    logic [CNT_BITS-1:0]   out_count_reg, out_count_next;
    ssoc_status_t          out_status_reg, out_status_next;

    // memory ports
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [VALUE_BITS-1:0] rd_data;

    // decoded input
    ssoc_cmd_t             in_cmd;
    logic [VALUE_BITS-1:0] in_value;
    logic                  in_accept;
    logic                  out_free;

    // probe datapath: both possible next ranges are prepared from registers,
    // the memory compare only selects one of them
    logic                  go_right;
    logic [CNT_BITS-1:0]   mid_p1;
    logic [CNT_BITS-1:0]   mid_right;
    logic [CNT_BITS-1:0]   mid_left;
    logic                  right_open;
    logic                  left_open;
    logic [CNT_BITS-1:0]   start_mid;

    ssoc_ram #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (VALUE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_cmd    = ssoc_cmd_t'(s_tuser);
    assign in_value  = s_tdata[VALUE_BITS-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign go_right   = strict_reg ? (rd_data <= target_reg) : (rd_data < target_reg);
    assign mid_p1     = mid_reg + CNT_BITS'(1);
    assign mid_right  = mid_p1 + ((hi_reg - mid_p1) >> 1);
    assign mid_left   = lo_reg + ((mid_reg - lo_reg) >> 1);
    assign right_open = (mid_p1 < hi_reg);
    assign left_open  = (lo_reg < mid_reg);
    assign start_mid  = lo_reg + ((hi_reg - lo_reg) >> 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (in_cmd == CMD_QUERY) ? ST_START : ST_RESP;
                end
            end
            ST_START:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_PROBE;
                end
                else if (strict_reg)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_PROBE:
            begin
                if (go_right ? !right_open : !left_open)
                begin
                    state_next = ST_START;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        fill_next       = fill_reg;
        last_next       = last_reg;
        strict_next     = strict_reg;
        target_next     = target_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        lower_next      = lower_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        wr_en           = 1'b0;
        wr_addr         = fill_reg[ADDR_BITS-1:0];
        wr_data         = in_value;
        rd_en           = 1'b0;
        rd_addr         = mid_reg[ADDR_BITS-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_count_next  = '0;
                    res_status_next = STATUS_OK;
                    target_next     = in_value;
                    case (in_cmd)
                        CMD_APPEND:
                        begin
                            if (fill_reg >= CNT_BITS'(DEPTH))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else if ((fill_reg != '0) && (in_value < last_reg))
                            begin
                                res_status_next = STATUS_ORDER;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + CNT_BITS'(1);
                                last_next = in_value;
                            end
                        end
                        CMD_QUERY:
                        begin
                            lo_next     = '0;
                            hi_next     = fill_reg;
                            strict_next = 1'b0;
                        end
                        CMD_CLEAR:
                        begin
                            fill_next = '0;
                            last_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_START:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = start_mid[ADDR_BITS-1:0];
                    mid_next = start_mid;
                end
                else if (!strict_reg)
                begin
                    // lower bound found; upper bound lies at or above it
                    lower_next  = lo_reg;
                    hi_next     = fill_reg;
                    strict_next = 1'b1;
                end
                else
                begin
                    res_count_next = lo_reg - lower_reg;
                end
            end
            ST_PROBE:
            begin
                if (go_right)
                begin
                    lo_next = mid_p1;
                    if (right_open)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = mid_right[ADDR_BITS-1:0];
                        mid_next = mid_right;
                    end
                end
                else
                begin
                    hi_next = mid_reg;
                    if (left_open)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = mid_left[ADDR_BITS-1:0];
                        mid_next = mid_left;
                    end
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = res_count_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            last_reg      <= '0;
            strict_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            last_reg      <= last_next;
            strict_reg    <= strict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        lower_reg      <= lower_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_WIDTH'({out_status_reg, out_count_reg});

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for sorted_store_occurrence_count: directed and random
// append, query and clear transactions with a scoreboard that mirrors the sorted store
// depends on ssoc_pkg and the rtl of sorted_store_occurrence_count
`timescale 1ns / 1ps

module testbench;
    import ssoc_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int VALUE_BITS   = 20;
    localparam int COUNT_BITS   = 11;
    localparam int IN_BITS      = 8 * ((VALUE_BITS + 7) / 8);
    localparam int OUT_BITS     = 8 * (($clog2(DEPTH + 1) + 9) / 8);
    localparam int RANDOM_ITEMS = 1750;
    localparam int IDLE_LIMIT   = 5000;

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct {
        logic [COUNT_BITS-1:0] match_count;
        ssoc_status_t          status;
    } occurrence_result_t;

    // mirror of the sorted store; predicts one result per accepted command
    class sorted_store_mirror;
        value_t             entry [DEPTH];
        int unsigned        fill_level;
        value_t             last_value;
        occurrence_result_t pending [$];
        int unsigned        mismatch_count;

        function new();
            fill_level     = 0;
            last_value     = '0;
            mismatch_count = 0;
        endfunction

        // binary search over the filled part: first entry above the target
        // (above set) or first entry not below it
        function int unsigned first_index(value_t target, bit above);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = fill_level;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (above ? (entry[mid] <= target) : (entry[mid] < target))
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function void note_command(ssoc_cmd_t cmd, value_t value);
            occurrence_result_t res;
            res.match_count = '0;
            res.status      = STATUS_OK;
            case (cmd)
                CMD_APPEND:
                begin
                    // full check comes before the order check
                    if (fill_level >= DEPTH)
                        res.status = STATUS_FULL;
                    else if (fill_level > 0 && value < last_value)
                        res.status = STATUS_ORDER;
                    else
                    begin
                        entry[fill_level] = value;
                        fill_level++;
                        last_value = value;
                    end
                end
                CMD_QUERY:
                    res.match_count = COUNT_BITS'(first_index(value, 1'b1)
                                                  - first_index(value, 1'b0));
                CMD_CLEAR:
                begin
                    fill_level = 0;
                    last_value = '0;
                end
                default: ;
            endcase
            pending.push_back(res);
        endfunction

        function void check_result(logic [COUNT_BITS-1:0] match_count, logic [1:0] status);
            occurrence_result_t exp_res;
            if (pending.size() == 0)
            begin
                $error("result transaction with no command outstanding: match_count %0d status %0d",
                       match_count, status);
                mismatch_count++;
                return;
            end
            exp_res = pending.pop_front();
            if (match_count !== exp_res.match_count)
            begin
                $error("match_count: expected %0d, actual %0d", exp_res.match_count, match_count);
                mismatch_count++;
            end
            if (status !== exp_res.status)
            begin
                $error("status: expected %0d, actual %0d", exp_res.status, status);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;   // value, zero padded
    logic [CMD_BITS-1:0] s_tuser;   // command
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;   // match_count, status, zero padded

    sorted_store_mirror book;
    int unsigned        items_sent;
    int unsigned        burst_left;

    sorted_store_occurrence_count #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one command transaction; the sender runs in bursts with random gaps
    task automatic send_command(input ssoc_cmd_t cmd, input value_t value);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_BITS'(value);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        book.note_command(cmd, value);
        items_sent++;
    endtask

    // hold off until every outstanding result has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (book.pending.size() != 0) @(posedge clk);
    endtask

    // next value for a well-formed append: many duplicates, small and large steps
    function automatic value_t next_ascending();
        int unsigned r;
        longint      v;
        r = $urandom_range(0, 9);
        if (book.fill_level == 0)
            return (r < 5) ? value_t'($urandom_range(0, 255))
                           : value_t'($urandom_range(0, (1 << VALUE_BITS) - 1));
        v = book.last_value;
        if (r >= 4 && r < 8)
            v += $urandom_range(1, 16);
        else if (r == 8)
            v += $urandom_range(1, 4096);
        else if (r == 9)
            v += $urandom_range(1, 1 << (VALUE_BITS - 1));
        // saturate at the top so the maximum value gets duplicates too
        if (v > (1 << VALUE_BITS) - 1)
            v = (1 << VALUE_BITS) - 1;
        return value_t'(v);
    endfunction

    // query target: mostly a stored value, some near misses, some anything
    function automatic value_t pick_target();
        int unsigned r;
        value_t      hit;
        r = $urandom_range(0, 9);
        if (book.fill_level == 0 || r >= 8)
            return value_t'($urandom_range(0, (1 << VALUE_BITS) - 1));
        hit = book.entry[$urandom_range(0, book.fill_level - 1)];
        if (r == 6)
            return hit + 1'b1;
        if (r == 7)
            return hit - 1'b1;
        return hit;
    endfunction

    // one random transaction within a well-formed sequence, with some noise
    task automatic random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            send_command(CMD_APPEND, next_ascending());
        else if (r < 80)
            send_command(CMD_QUERY, pick_target());
        else if (r < 88)
            // out of order unless the last value is zero
            send_command(CMD_APPEND, (book.last_value == 0) ? value_t'($urandom())
                                     : value_t'($urandom_range(0, book.last_value - 1)));
        else if (r < 92)
            send_command(CMD_NONE, value_t'($urandom()));
        else
            send_command(ssoc_cmd_t'($urandom_range(0, 3)), value_t'($urandom()));
    endtask

    // receiver: ready pattern changes mode at random
    initial
    begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        int unsigned stall_left;
        m_tready   = 1'b0;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2:
                    begin
                        // mostly ready, with an occasional long stall
                        if ($urandom_range(0, 9) == 0)
                        begin
                            stall_left = $urandom_range(1, 40);
                            m_tready <= 1'b0;
                        end
                        else
                            m_tready <= 1'b1;
                    end
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            book.check_result(m_tdata[COUNT_BITS-1:0], m_tdata[COUNT_BITS+1:COUNT_BITS]);
    end

    // watchdog on cycles in which no transaction is accepted on either side
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned directed_items;
        int unsigned phase;
        int unsigned phase_items;
        book       = new();
        items_sent = 0;
        burst_left = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_NONE;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty store, duplicates, order errors, extremes, clear, unused command
        send_command(CMD_QUERY,  20'h00000);
        send_command(CMD_QUERY,  20'hFFFFF);
        send_command(CMD_NONE,   20'hFFFFF);
        send_command(CMD_APPEND, 20'h00000);
        send_command(CMD_APPEND, 20'h00000);
        send_command(CMD_APPEND, 20'h00005);
        send_command(CMD_APPEND, 20'h00003);
        send_command(CMD_QUERY,  20'h00000);
        send_command(CMD_QUERY,  20'h00005);
        send_command(CMD_QUERY,  20'h00004);
        send_command(CMD_APPEND, 20'hFFFFF);
        send_command(CMD_APPEND, 20'hFFFFF);
        send_command(CMD_APPEND, 20'h00007);
        send_command(CMD_QUERY,  20'hFFFFF);
        send_command(CMD_CLEAR,  20'hFFFFF);
        // after a clear any value is taken, even below the old last value
        send_command(CMD_APPEND, 20'h0000A);
        send_command(CMD_QUERY,  20'h0000A);
        send_command(CMD_QUERY,  20'h00000);
        send_command(CMD_CLEAR,  20'h00000);
        send_command(CMD_QUERY,  20'h0000A);
        send_command(CMD_APPEND, 20'h55555);
        send_command(CMD_APPEND, 20'hAAAAA);
        send_command(CMD_QUERY,  20'h55555);
        send_command(CMD_QUERY,  20'hAAAAA);
        directed_items = items_sent;
        drain_results();

        phase = 0;
        while (items_sent < directed_items + RANDOM_ITEMS)
        begin
            if (phase == 2)
            begin
                // fill the store completely, then hit it with appends and queries
                send_command(CMD_CLEAR, value_t'($urandom()));
                repeat (DEPTH) send_command(CMD_APPEND, next_ascending());
                send_command(CMD_APPEND, book.last_value);
                send_command(CMD_APPEND, '0);
                send_command(CMD_QUERY, book.entry[0]);
                send_command(CMD_QUERY, book.entry[DEPTH-1]);
                repeat (40) random_item();
                drain_results();
            end
            else
            begin
                if ($urandom_range(0, 9) != 0)
                    send_command(CMD_CLEAR, value_t'($urandom()));
                phase_items = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250)
                                                          : $urandom_range(5, 60);
                repeat (phase_items) random_item();
                if ($urandom_range(0, 2) == 0)
                    drain_results();
            end
            phase++;
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (book.mismatch_count == 0 && book.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
